FILE: rtl/pva_pkg.sv
`default_nettype none

package pva_pkg;

   // Table size and level precision.
   localparam int VOICES     = 8;
   localparam int LEVEL_BITS = 16;

   // Derived widths.
   localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int VCNT_W  = $clog2(VOICES + 1);

   // Fixed field widths of the item channels.
   localparam int CMD_W    = 3;
   localparam int NOTE_W   = 7;
   localparam int SV_W     = 3;
   localparam int SL_W     = 16;
   localparam int CHOSEN_W = 3;
   localparam int KIND_W   = 3;
   localparam int MASK_W   = 8;
   localparam int COUNT_W  = 4;

   // Command codes carried on the request side.
   typedef enum logic [CMD_W-1:0] {
      CMD_NOTE_ON  = 3'd0,
      CMD_NOTE_OFF = 3'd1,
      CMD_SUSTAIN  = 3'd2,
      CMD_ALL_OFF  = 3'd3,
      CMD_STATUS   = 3'd4
   } cmd_type;

   // How a note-on found its voice.
   typedef enum logic [KIND_W-1:0] {
      KIND_NONE     = 3'd0,
      KIND_RETRIG   = 3'd1,
      KIND_FREE     = 3'd2,
      KIND_QUIETEST = 3'd3,
      KIND_STEAL_RR = 3'd4
   } kind_type;

   // One row of the voice table.
   typedef struct packed {
      logic [NOTE_W-1:0]     note;
      logic                  gated;
      logic                  sounding;
      logic [LEVEL_BITS-1:0] level;
   } voice_entry_type;

   // Write port of the voice table.
   typedef struct packed {
      logic              en;
      logic [VIDX_W-1:0] addr;
      voice_entry_type   entry;
   } table_wr_type;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic              clear;
      logic              scan;
      logic              count;
      cmd_type           cmd;
      logic [NOTE_W-1:0] note;
      logic              pedal_old;
      logic              pedal_new;
      logic [VIDX_W-1:0] rr;
   } scan_ctl_type;

   // Running results of the scan unit.
   typedef struct packed {
      logic              retrig_found;
      logic [VIDX_W-1:0] retrig_idx;
      logic              free_found;
      logic [VIDX_W-1:0] free_idx;
      logic              quiet_found;
      logic [VIDX_W-1:0] quiet_idx;
      logic [MASK_W-1:0] released;
      logic [VCNT_W-1:0] count;
   } scan_res_type;

endpackage

`default_nettype wire

FILE: rtl/pva_voice_table.sv
`default_nettype none

module pva_voice_table (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [pva_pkg::VIDX_W-1:0] rd_addr,
   output pva_pkg::voice_entry_type        rd_entry,
   input  pva_pkg::table_wr_type           wr
);
   import pva_pkg::*;

   voice_entry_type voice_ff [VOICES];

   // One write port; every row starts out silent and ungated.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            voice_ff[v] <= '0;
         end
      end else if (wr.en) begin
         voice_ff[wr.addr] <= wr.entry;
      end
   end

   // One read port at the address the sequencer selects.
   assign rd_entry = voice_ff[rd_addr];

endmodule

`default_nettype wire

FILE: rtl/pva_scan_unit.sv
`default_nettype none

module pva_scan_unit (
   input  wire logic                       clock,
   input  pva_pkg::scan_ctl_type           ctl,
   input  wire logic [pva_pkg::VIDX_W-1:0] idx,
   input  pva_pkg::voice_entry_type        entry,
   output logic                            clear_gate,
   output pva_pkg::scan_res_type           res
);
   import pva_pkg::*;

   scan_res_type            res_ff;
   scan_res_type            res_in;
   logic [LEVEL_BITS-1:0]   quiet_level_ff;
   logic [LEVEL_BITS-1:0]   quiet_level_in;
   logic [VIDX_W:0]         free_dist_ff;
   logic [VIDX_W:0]         free_dist_in;
   logic                    held_before;
   logic                    held_after;
   logic                    note_match;
   logic                    quiet_better;
   logic [VIDX_W:0]         rr_offset;
   logic                    rel_hit;
   logic [MASK_W-1:0]       bit_sel;

   // Per-entry flags for the voice under the scan pointer.
   always_comb begin
      held_before  = entry.gated | (ctl.pedal_old & entry.sounding);
      held_after   = entry.gated | (ctl.pedal_new & entry.sounding);
      note_match   = (entry.note == ctl.note);
      quiet_better = !res_ff.quiet_found || (entry.level < quiet_level_ff);
      if (idx >= ctl.rr) begin
         rr_offset = {1'b0, idx} - {1'b0, ctl.rr};
      end else begin
         rr_offset = {1'b0, idx} + (VIDX_W + 1)'(VOICES) - {1'b0, ctl.rr};
      end
      bit_sel = MASK_W'(1) << idx;
   end

   // Which voices this command releases, and which lose their gate.
   always_comb begin
      rel_hit    = 1'b0;
      clear_gate = 1'b0;
      case (ctl.cmd)
         CMD_NOTE_OFF: begin
            rel_hit    = entry.gated & note_match;
            clear_gate = ctl.scan & entry.gated & note_match;
         end
         CMD_SUSTAIN: begin
            rel_hit = held_before & ~held_after;
         end
         CMD_ALL_OFF: begin
            rel_hit    = held_before;
            clear_gate = ctl.scan;
         end
         default: begin
            rel_hit    = 1'b0;
            clear_gate = 1'b0;
         end
      endcase
   end

   // Accumulate the candidates, the released mask and the sounding count.
   always_comb begin
      res_in         = res_ff;
      quiet_level_in = quiet_level_ff;
      free_dist_in   = free_dist_ff;
      if (ctl.clear) begin
         res_in         = '0;
         quiet_level_in = '0;
         free_dist_in   = '0;
      end else if (ctl.scan) begin
         if (ctl.cmd == CMD_NOTE_ON) begin
            // Retrigger keeps the lowest matching index.
            if (!res_ff.retrig_found && note_match && held_before) begin
               res_in.retrig_found = 1'b1;
               res_in.retrig_idx   = idx;
            end
            // Free voice at or closest after the round-robin pointer.
            if (!entry.sounding && (!res_ff.free_found || rr_offset < free_dist_ff)) begin
               res_in.free_found = 1'b1;
               res_in.free_idx   = idx;
               free_dist_in      = rr_offset;
            end
            // Quietest released voice; strictly lower level wins.
            if (!held_before && quiet_better) begin
               res_in.quiet_found = 1'b1;
               res_in.quiet_idx   = idx;
               quiet_level_in     = entry.level;
            end
         end
         if (rel_hit) begin
            res_in.released = res_ff.released | bit_sel;
         end
      end else if (ctl.count) begin
         res_in.count = res_ff.count + VCNT_W'(entry.sounding);
      end
   end

   always_ff @(posedge clock) begin
      res_ff         <= res_in;
      quiet_level_ff <= quiet_level_in;
      free_dist_ff   <= free_dist_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

FILE: rtl/poly_voice_allocator_core.sv
`default_nettype none

// Each item takes a pass over the voices to select and release, an update step, a pass
// to count sounding voices and a load of the output register, all on one read port.
// No new item is accepted until the current one has been loaded into the output register,
// and that load waits while a previous result is still held there and not taken.
// Reset (synchronous, active high) clears the voice table, the round-robin pointer, the
// pedal and the output valid flag, and returns the sequencer to idle.
module poly_voice_allocator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [6:0] note, [7] pedal_down, [10:8] status_voice, [11] status_sounding,
   // [27:12] status_level, [31:28] zero
   input  wire logic [31:0] req_tdata,
   // [2:0] cmd
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [2:0] chosen_voice, [10:3] released_mask, [14:11] sounding_count, [15] zero
   output logic [15:0]      rsp_tdata,
   // [2:0] choice_kind
   output logic [2:0]       rsp_tuser
);
   import pva_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_APPLY = 5'b00100,
      ST_COUNT = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [VIDX_W-1:0]     idx_ff, idx_in;
   logic [VIDX_W-1:0]     rr_ff, rr_in;
   logic                  pedal_ff, pedal_in;
   cmd_type               cmd_ff, cmd_in;
   logic [NOTE_W-1:0]     note_ff, note_in;
   logic                  pdown_ff, pdown_in;
   logic [SV_W-1:0]       sv_ff, sv_in;
   logic                  ss_ff, ss_in;
   logic [LEVEL_BITS-1:0] sl_ff, sl_in;
   logic [CHOSEN_W-1:0]   chosen_ff, chosen_in;
   kind_type              kind_ff, kind_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_data_ff, rsp_data_in;
   kind_type              rsp_kind_ff, rsp_kind_in;

   logic                  req_accept;
   logic                  out_load;
   logic                  idx_last;
   logic                  sv_valid;
   logic [VIDX_W-1:0]     sv_addr;
   logic [VIDX_W-1:0]     chosen_sel;
   kind_type              kind_sel;
   logic [VIDX_W-1:0]     rd_addr;
   voice_entry_type       rd_entry;
   table_wr_type          wr;
   scan_ctl_type          ctl;
   logic                  clear_gate;
   scan_res_type          res;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign req_accept = req_tvalid & req_tready;
   assign out_load   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);
   assign idx_last   = (idx_ff == VIDX_W'(VOICES - 1));
   assign sv_valid   = (int'(sv_ff) < VOICES);
   assign sv_addr    = VIDX_W'(sv_ff);

   // Priority of the note-on choice, from the finished scan.
   always_comb begin
      if (res.retrig_found) begin
         kind_sel   = KIND_RETRIG;
         chosen_sel = res.retrig_idx;
      end else if (res.free_found) begin
         kind_sel   = KIND_FREE;
         chosen_sel = res.free_idx;
      end else if (res.quiet_found) begin
         kind_sel   = KIND_QUIETEST;
         chosen_sel = res.quiet_idx;
      end else begin
         kind_sel   = KIND_STEAL_RR;
         chosen_sel = rr_ff;
      end
   end

   // Table read address: scan pointer, or the row the update touches.
   always_comb begin
      if (state_ff == ST_APPLY) begin
         rd_addr = (cmd_ff == CMD_NOTE_ON) ? chosen_sel : sv_addr;
      end else begin
         rd_addr = idx_ff;
      end
   end

   // Table write: gate clears during the scan, then the single update.
   always_comb begin
      wr       = '0;
      wr.entry = rd_entry;
      if (state_ff == ST_SCAN) begin
         wr.en          = clear_gate;
         wr.addr        = idx_ff;
         wr.entry.gated = 1'b0;
      end else if (state_ff == ST_APPLY) begin
         if (cmd_ff == CMD_NOTE_ON) begin
            wr.en             = 1'b1;
            wr.addr           = chosen_sel;
            wr.entry.note     = note_ff;
            wr.entry.gated    = 1'b1;
            wr.entry.sounding = 1'b1;
         end else if (cmd_ff == CMD_STATUS) begin
            wr.en             = sv_valid;
            wr.addr           = sv_addr;
            wr.entry.sounding = ss_ff;
            wr.entry.level    = sl_ff;
         end
      end
   end

   // Scan unit control.
   always_comb begin
      ctl           = '0;
      ctl.clear     = req_accept;
      ctl.scan      = (state_ff == ST_SCAN);
      ctl.count     = (state_ff == ST_COUNT);
      ctl.cmd       = cmd_ff;
      ctl.note      = note_ff;
      ctl.pedal_old = pedal_ff;
      ctl.pedal_new = pdown_ff;
      ctl.rr        = rr_ff;
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      rr_in     = rr_ff;
      pedal_in  = pedal_ff;
      cmd_in    = cmd_ff;
      note_in   = note_ff;
      pdown_in  = pdown_ff;
      sv_in     = sv_ff;
      ss_in     = ss_ff;
      sl_in     = sl_ff;
      chosen_in = chosen_ff;
      kind_in   = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = cmd_type'(req_tuser);
               note_in  = req_tdata[6:0];
               pdown_in = req_tdata[7];
               sv_in    = req_tdata[10:8];
               ss_in    = req_tdata[11];
               sl_in    = LEVEL_BITS'(req_tdata[27:12]);
               idx_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + VIDX_W'(1);
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            chosen_in = '0;
            kind_in   = KIND_NONE;
            case (cmd_ff)
               CMD_NOTE_ON: begin
                  chosen_in = CHOSEN_W'(chosen_sel);
                  kind_in   = kind_sel;
                  if (kind_sel != KIND_RETRIG) begin
                     rr_in = (chosen_sel == VIDX_W'(VOICES - 1)) ? '0
                                                                 : chosen_sel + VIDX_W'(1);
                  end
               end
               CMD_SUSTAIN: pedal_in = pdown_ff;
               CMD_ALL_OFF: pedal_in = 1'b0;
               default:     pedal_in = pedal_ff;
            endcase
            idx_in   = '0;
            state_in = ST_COUNT;
         end
         ST_COUNT: begin
            idx_in = idx_ff + VIDX_W'(1);
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loads a finished result once the previous one has left.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, COUNT_W'(res.count), res.released, chosen_ff};
         rsp_kind_in  = kind_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rr_ff        <= '0;
         pedal_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rr_ff        <= rr_in;
         pedal_ff     <= pedal_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item payload and result registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      note_ff     <= note_in;
      pdown_ff    <= pdown_in;
      sv_ff       <= sv_in;
      ss_ff       <= ss_in;
      sl_ff       <= sl_in;
      chosen_ff   <= chosen_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   pva_voice_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   pva_scan_unit u_scan (
      .clock      (clock),
      .ctl        (ctl),
      .idx        (idx_ff),
      .entry      (rd_entry),
      .clear_gate (clear_gate),
      .res        (res)
   );

   // Result item.
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_kind_ff;

`ifndef SYNTHESIS
   // A waiting result item stays put until it is taken.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
      (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("waiting result changed before it was taken");

   // A retrigger leaves the round-robin pointer where it was.
   a_retrig_keeps_rr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && cmd_ff == CMD_NOTE_ON && kind_sel == KIND_RETRIG)
      |=> $stable(rr_ff))
      else $error("retrigger moved the round-robin pointer");

   // The sounding count never exceeds the table size.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[14:11]) <= VOICES))
      else $error("sounding count out of range");

   // Only a note-on reports a choice.
   a_kind_only_note_on: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && cmd_ff != CMD_NOTE_ON) |->
      (kind_ff == KIND_NONE && chosen_ff == '0))
      else $error("choice reported for a command other than note-on");

   // An accepted item always starts with the selection pass.
   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_SCAN && idx_ff == '0))
      else $error("accepted item did not start the scan");
`endif

endmodule

`default_nettype wire
